### src/sgsc_pkg.sv
package sgsc_pkg;

  localparam int AngleFracBits = 14;
  localparam int AngW = 15;
  localparam int StepW = 12;
  localparam int FuelW = 16;
  localparam int MaskW = 5;
  localparam int NumLegs = 3;
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  // pi held as round(pi * 2^30); notch and gear-down angles are rounded from it.
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam logic [63:0] FlapNotchWide =
      ((PiQ30 / 18) + (64'd1 << (29 - AngleFracBits))) >> (30 - AngleFracBits);
  localparam logic [63:0] GearDownWide =
      (PiQ30 + (64'd1 << (30 - AngleFracBits))) >> (31 - AngleFracBits);

  typedef logic [AngW-1:0]  angle_t;
  typedef logic [StepW-1:0] step_t;
  typedef logic [FuelW-1:0] fuel_t;

  localparam angle_t FlapNotch = FlapNotchWide[AngW-1:0];
  localparam angle_t GearDown  = GearDownWide[AngW-1:0];

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_FLAP_DOWN = 3'd1;
  localparam logic [2:0] REQ_FLAP_UP   = 3'd2;
  localparam logic [2:0] REQ_BRK_EXT   = 3'd3;
  localparam logic [2:0] REQ_BRK_RET   = 3'd4;

  localparam logic [2:0] REG_MAX_FLAP   = 3'd0;
  localparam logic [2:0] REG_FLAP_STEP  = 3'd1;
  localparam logic [2:0] REG_BRAKE_STEP = 3'd2;
  localparam logic [2:0] REG_GEAR_STEP  = 3'd3;
  localparam logic [2:0] REG_MAX_BRAKE  = 3'd4;
  localparam logic [2:0] REG_BRK_NOTCH  = 3'd5;
  localparam logic [2:0] REG_LOW_FUEL   = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_FLAP_DOWN,
    OP_FLAP_UP,
    OP_BRK_EXT,
    OP_BRK_RET,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]       req_type;
    logic             gear_handle_down;
    logic             ground_contact;
    logic             wheel_brakes_on;
    fuel_t            fuel_level;
    logic [MaskW-1:0] working_mask;
  } in_item_t;

  typedef struct packed {
    angle_t     flap_position;
    angle_t     flap_target;
    angle_t     brake_position;
    angle_t     brake_target;
    angle_t     nose_gear_angle;
    angle_t     right_gear_angle;
    angle_t     left_gear_angle;
    logic [2:0] gear_up_flags;
    logic [2:0] warning_flags;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic             gear_handle_down;
    logic             ground_contact;
    logic             wheel_brakes_on;
    fuel_t            fuel_level;
    logic [MaskW-1:0] working_mask;
  } q_entry_t;

  typedef struct packed {
    angle_t max_flap;
    step_t  flap_step;
    step_t  brake_step;
    step_t  gear_step;
    angle_t max_brake;
    angle_t brake_notch;
    fuel_t  low_fuel_level;
  } cfg_t;

endpackage

### src/sgsc_regs.sv
module sgsc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sgsc_pkg::PaddrW-1:0] paddr,
  input  logic [sgsc_pkg::PdataW-1:0] pwdata,
  output logic [sgsc_pkg::PdataW-1:0] prdata,
  output sgsc_pkg::cfg_t             cfg_o
);
  import sgsc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_FLAP:   cfg_d.max_flap       = pwdata[AngW-1:0];
        REG_FLAP_STEP:  cfg_d.flap_step      = pwdata[StepW-1:0];
        REG_BRAKE_STEP: cfg_d.brake_step     = pwdata[StepW-1:0];
        REG_GEAR_STEP:  cfg_d.gear_step      = pwdata[StepW-1:0];
        REG_MAX_BRAKE:  cfg_d.max_brake      = pwdata[AngW-1:0];
        REG_BRK_NOTCH:  cfg_d.brake_notch    = pwdata[AngW-1:0];
        REG_LOW_FUEL:   cfg_d.low_fuel_level = pwdata[FuelW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_FLAP:   prdata = PdataW'(cfg_q.max_flap);
      REG_FLAP_STEP:  prdata = PdataW'(cfg_q.flap_step);
      REG_BRAKE_STEP: prdata = PdataW'(cfg_q.brake_step);
      REG_GEAR_STEP:  prdata = PdataW'(cfg_q.gear_step);
      REG_MAX_BRAKE:  prdata = PdataW'(cfg_q.max_brake);
      REG_BRK_NOTCH:  prdata = PdataW'(cfg_q.brake_notch);
      REG_LOW_FUEL:   prdata = PdataW'(cfg_q.low_fuel_level);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_flap       <= AngW'(6434);
      cfg_q.flap_step      <= StepW'(80);
      cfg_q.brake_step     <= StepW'(80);
      cfg_q.gear_step      <= StepW'(40);
      cfg_q.max_brake      <= AngW'(12868);
      cfg_q.brake_notch    <= AngW'(4289);
      cfg_q.low_fuel_level <= FuelW'(1000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/sgsc_front.sv
module sgsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sgsc_pkg::in_item_t   in_item_i,
  input  logic                 pop_i,
  output logic                 q_valid_o,
  output sgsc_pkg::q_entry_t   q_entry_o
);
  import sgsc_pkg::*;

  q_entry_t   entry;
  q_entry_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    entry.gear_handle_down = in_item_i.gear_handle_down;
    entry.ground_contact   = in_item_i.ground_contact;
    entry.wheel_brakes_on  = in_item_i.wheel_brakes_on;
    entry.fuel_level       = in_item_i.fuel_level;
    entry.working_mask     = in_item_i.working_mask;
    unique case (in_item_i.req_type)
      REQ_TICK:      entry.op = OP_TICK;
      REQ_FLAP_DOWN: entry.op = OP_FLAP_DOWN;
      REQ_FLAP_UP:   entry.op = OP_FLAP_UP;
      REQ_BRK_EXT:   entry.op = OP_BRK_EXT;
      REQ_BRK_RET:   entry.op = OP_BRK_RET;
      default:       entry.op = OP_NOP;
    endcase
  end

  assign in_stall_o = cnt_q[1];
  assign push       = in_valid_i && !cnt_q[1];
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = pop_i && q_valid_o;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

### src/sgsc_back.sv
module sgsc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sgsc_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  sgsc_pkg::q_entry_t  q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sgsc_pkg::out_item_t out_item_o
);
  import sgsc_pkg::*;

  angle_t     flap_goal_q, flap_goal_d, flap_now_q, flap_now_d;
  angle_t     brake_goal_q, brake_goal_d, brake_now_q, brake_now_d;
  angle_t     gear_q [NumLegs];
  angle_t     gear_d [NumLegs];
  logic [2:0] up_q, up_d, warn_q, warn_d;
  logic       out_valid_q;
  out_item_t  out_q;
  logic [AngW:0] flap_sum, brake_sum;

  function automatic angle_t slew(angle_t now, angle_t goal, step_t step);
    logic [AngW:0] up_sum;
    logic [AngW:0] lim;
    angle_t        res;
    up_sum = {1'b0, now} + (AngW+1)'(step);
    lim    = {1'b0, goal} + (AngW+1)'(step);
    res    = now;
    if (goal > now) begin
      res = (up_sum > {1'b0, goal}) ? goal : up_sum[AngW-1:0];
    end else if (goal < now) begin
      res = ({1'b0, now} < lim) ? goal : now - AngW'(step);
    end
    return res;
  endfunction

  // The back end takes the next item whenever the output register is free or draining.
  assign pop_o    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign flap_sum  = {1'b0, flap_goal_q} + {1'b0, FlapNotch};
  assign brake_sum = {1'b0, brake_goal_q} + {1'b0, cfg_i.brake_notch};

  always_comb begin
    logic [AngW:0] leg_sum;
    flap_goal_d  = flap_goal_q;
    flap_now_d   = flap_now_q;
    brake_goal_d = brake_goal_q;
    brake_now_d  = brake_now_q;
    gear_d       = gear_q;
    up_d         = up_q;
    warn_d       = warn_q;
    leg_sum      = '0;
    unique case (q_entry_i.op)
      OP_TICK: begin
        if (q_entry_i.working_mask[0]) begin
          flap_now_d = slew(flap_now_q, flap_goal_q, cfg_i.flap_step);
        end
        if (q_entry_i.working_mask[1]) begin
          brake_now_d = slew(brake_now_q, brake_goal_q, cfg_i.brake_step);
        end
        for (int l = 0; l < NumLegs; l++) begin
          leg_sum = {1'b0, gear_q[l]} + (AngW+1)'(cfg_i.gear_step);
          if (q_entry_i.working_mask[2+l]) begin
            if (q_entry_i.gear_handle_down) begin
              if (gear_q[l] != GearDown) begin
                gear_d[l] = (leg_sum > {1'b0, GearDown}) ? GearDown : leg_sum[AngW-1:0];
                up_d[l]   = 1'b0;
              end
            end else if (gear_q[l] != '0 && !q_entry_i.ground_contact) begin
              // Only a step that would pass below zero marks the leg as up.
              if (gear_q[l] < AngW'(cfg_i.gear_step)) begin
                gear_d[l] = '0;
                up_d[l]   = 1'b1;
              end else begin
                gear_d[l] = gear_q[l] - AngW'(cfg_i.gear_step);
              end
            end
          end
        end
        warn_d = {brake_goal_q != '0, q_entry_i.wheel_brakes_on,
                  q_entry_i.fuel_level < cfg_i.low_fuel_level};
      end
      OP_FLAP_DOWN: begin
        flap_goal_d = (flap_sum > {1'b0, cfg_i.max_flap}) ? cfg_i.max_flap
                                                          : flap_sum[AngW-1:0];
      end
      OP_FLAP_UP: begin
        flap_goal_d = (flap_goal_q < FlapNotch) ? '0 : flap_goal_q - FlapNotch;
      end
      OP_BRK_EXT: begin
        brake_goal_d = (brake_sum > {1'b0, cfg_i.max_brake}) ? cfg_i.max_brake
                                                             : brake_sum[AngW-1:0];
      end
      OP_BRK_RET: begin
        brake_goal_d = (brake_goal_q < cfg_i.brake_notch) ? '0
                                                          : brake_goal_q - cfg_i.brake_notch;
      end
      default: begin
        flap_goal_d = flap_goal_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flap_goal_q  <= '0;
      flap_now_q   <= '0;
      brake_goal_q <= '0;
      brake_now_q  <= '0;
      for (int l = 0; l < NumLegs; l++) begin
        gear_q[l] <= GearDown;
      end
      up_q        <= '0;
      warn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        flap_goal_q  <= flap_goal_d;
        flap_now_q   <= flap_now_d;
        brake_goal_q <= brake_goal_d;
        brake_now_q  <= brake_now_d;
        gear_q       <= gear_d;
        up_q         <= up_d;
        warn_q       <= warn_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.flap_position    <= flap_now_d;
      out_q.flap_target      <= flap_goal_d;
      out_q.brake_position   <= brake_now_d;
      out_q.brake_target     <= brake_goal_d;
      out_q.nose_gear_angle  <= gear_d[0];
      out_q.right_gear_angle <= gear_d[1];
      out_q.left_gear_angle  <= gear_d[2];
      out_q.gear_up_flags    <= up_d;
      out_q.warning_flags    <= warn_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### src/surface_and_gear_slew_control_core.sv
// Results come from the back end's output register, which loads when an item leaves the queue.
// Throughput: one item per cycle while the output is not stalled; the state update for every
// item is combinational add-and-clamp logic in the back end.
// A two-entry queue decouples the input from the back end and its output register.
// Reset: flaps and speed brake at zero, all gear legs down, flags clear,
// queue and output empty, registers at their documented defaults.
module surface_and_gear_slew_control_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sgsc_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sgsc_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgsc_pkg::PaddrW-1:0] paddr,
  input  logic [sgsc_pkg::PdataW-1:0] pwdata,
  output logic [sgsc_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import sgsc_pkg::*;

  cfg_t     cfg;
  logic     q_valid, pop;
  q_entry_t q_entry;

  assign pready = 1'b1;

  sgsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  sgsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (pop),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry)
  );

  sgsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
